// File: hdl/so_pkg.sv
// Shared types, constants and the quarter-wave sine table for the sine oscillator.
// Depends on nothing; every other file of the block but so_tick_if imports it.
`timescale 1ns / 1ps

package so_pkg;

  // Phase accumulator width and table address width.
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int TableSize       = 1 << TABLE_ADDR_BITS;

  // Register widths of the configuration port.
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 2;

  // pi/2 in Q30, the step of the table angle before scaling by the address.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic signed [63:0] OneQ30 = 64'sd1073741824;

  typedef logic [PHASE_BITS-1:0]      phase_t;
  typedef logic [TABLE_ADDR_BITS-1:0] table_addr_t;
  typedef logic [15:0]                entry_t;
  typedef logic signed [15:0]         sample_t;
  typedef entry_t                     sine_rom_t [TableSize];

  localparam sample_t FullScale = 16'sd32767;
  localparam sample_t MinSample = -16'sd32768;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPhaseIncrement = 2'd0,
    CfgPhaseOffset    = 2'd1,
    CfgAmplitude      = 2'd2
  } cfg_idx_e;

  // Quadrant and table index taken from the top bits of the sample phase.
  typedef struct packed {
    logic [1:0]  quad;
    table_addr_t idx;
  } phase_sel_t;

  // Table read result with the quadrant controls that travel beside it.
  typedef struct packed {
    entry_t entry;
    logic   peak;
    logic   neg;
  } lut_t;

  // Fills the quarter-wave table at elaboration: a Q30 angle, an odd Taylor
  // series up to the x^25 term with every term truncated, then rounding to Q15.
  // Each term divides the previous one by (2k)(2k+1), written out as constants.
  function automatic sine_rom_t build_sine_table();
    sine_rom_t         rom;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    logic [63:0]       scaled;
    for (int i = 0; i < TableSize; i++) begin
      x    = (HalfPiQ30 * 64'(i)) >> TABLE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd342;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd420;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd506;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd600;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > OneQ30) begin
        sum = OneQ30;
      end
      scaled = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      rom[i] = scaled[15:0];
    end
    return rom;
  endfunction

endpackage

// File: hdl/so_tick_if.sv
// Tick channel: one transfer asks for one sample.
// Depends on so_pkg for nothing but shares the block's valid/ready convention.
`timescale 1ns / 1ps

interface so_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// File: hdl/so_sample_if.sv
// Sample channel: one transfer carries one signed 16-bit output sample.
// Depends on so_pkg for the sample type.
`timescale 1ns / 1ps

interface so_sample_if;
  logic            valid;
  logic            ready;
  so_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/so_phase.sv
// Phase stage: the phase accumulator and the registered sample phase selection.
// Depends on so_pkg and so_tick_if.
`timescale 1ns / 1ps

module so_phase (
  input  logic                clk_i,
  input  logic                rst_ni,
  so_tick_if.sink             tick_i,
  input  logic [31:0]         phase_increment_i,
  input  logic [31:0]         phase_offset_i,
  output logic                valid_o,
  input  logic                ready_i,
  output so_pkg::phase_sel_t  sel_o
);
  import so_pkg::*;

  phase_t     acc_q;
  phase_t     base;
  phase_t     phase;
  logic       valid_q;
  logic       xfer;
  phase_sel_t sel_q;

  // The stage takes a tick when it is empty or its content moves on.
  assign tick_i.ready = !valid_q || ready_i;
  assign xfer         = tick_i.valid && tick_i.ready;

  // A restart zeroes the accumulator before this tick's phase is formed.
  always_comb begin
    base  = tick_i.restart ? '0 : acc_q;
    phase = base + phase_t'(phase_offset_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (tick_i.ready) begin
        valid_q <= tick_i.valid;
      end
      if (xfer) begin
        acc_q <= base + phase_t'(phase_increment_i);
      end
    end
  end

  // Only the quadrant and table index bits of the phase are kept.
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      sel_q <= phase[PHASE_BITS-1 -: TABLE_ADDR_BITS + 2];
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

endmodule

// File: hdl/so_lut.sv
// Table stage: mirrors the index by quadrant and reads the quarter-wave ROM.
// Depends on so_pkg for the table contents and stage types.
`timescale 1ns / 1ps

module so_lut (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  so_pkg::phase_sel_t sel_i,
  output logic               valid_o,
  input  logic               ready_i,
  output so_pkg::lut_t       lut_o
);
  import so_pkg::*;

  localparam sine_rom_t SineRom = build_sine_table();

  table_addr_t addr;
  logic        load;
  logic        valid_q;
  entry_t      entry_q;
  logic        peak_q;
  logic        neg_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Odd quadrants run the table backwards; their index zero is the peak.
  assign addr = sel_i.quad[0] ? (table_addr_t'(0) - sel_i.idx) : sel_i.idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Registered ROM read with the sign and peak flags alongside.
  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= SineRom[addr];
      peak_q  <= sel_i.quad[0] && (sel_i.idx == '0);
      neg_q   <= sel_i.quad[1];
    end
  end

  assign valid_o = valid_q;
  assign lut_o   = '{entry: entry_q, peak: peak_q, neg: neg_q};

endmodule

// File: hdl/so_mult.sv
// Gain stage: signs the table value, scales it by the amplitude and saturates.
// Depends on so_pkg and so_sample_if.
`timescale 1ns / 1ps

module so_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  so_pkg::lut_t    lut_i,
  input  so_pkg::sample_t amplitude_i,
  so_sample_if.source     sample_o
);
  import so_pkg::*;

  sample_t            mag;
  sample_t            sine;
  logic signed [31:0] prod;
  logic signed [16:0] shifted;
  sample_t            sample_d;
  sample_t            sample_q;
  logic               valid_q;
  logic               load;

  assign ready_o = !valid_q || sample_o.ready;
  assign load    = valid_i && ready_o;

  // Q1.15 times Q1.15, floored back to Q1.15 and clamped to 16 bits.
  always_comb begin
    mag     = lut_i.peak ? FullScale : $signed(lut_i.entry);
    sine    = lut_i.neg ? -mag : mag;
    prod    = amplitude_i * sine;
    shifted = prod[31:15];
    if (shifted[16] != shifted[15]) begin
      sample_d = shifted[16] ? MinSample : FullScale;
    end else begin
      sample_d = shifted[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o.valid  = valid_q;
  assign sample_o.sample = sample_q;

endmodule

// File: hdl/sine_oscillator.sv
// Sine oscillator: a tick transfer yields its sample through the phase, table and gain
// stage registers in turn; one tick per cycle is taken when the output keeps up, set by
// the registered ROM read and the single 16x16 multiply in their own stages. An empty
// stage fills while a later one stalls. Reset empties the pipeline, zeroes the phase
// accumulator, clears phase increment and offset, and sets amplitude to 32767.
// Depends on so_pkg, so_tick_if, so_sample_if, so_phase, so_lut and so_mult.
`timescale 1ns / 1ps

module sine_oscillator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [so_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [so_pkg::CfgDataW-1:0]   cfg_data_i,
  so_tick_if.sink                       tick_i,
  so_sample_if.source                   sample_o
);
  import so_pkg::*;

  logic [31:0] phase_increment_q;
  logic [31:0] phase_offset_q;
  sample_t     amplitude_q;

  logic        ph_valid;
  logic        ph_ready;
  phase_sel_t  ph_sel;
  logic        lut_valid;
  logic        lut_ready;
  lut_t        lut;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_increment_q <= '0;
      phase_offset_q    <= '0;
      amplitude_q       <= FullScale;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPhaseIncrement: phase_increment_q <= cfg_data_i[31:0];
        CfgPhaseOffset:    phase_offset_q    <= cfg_data_i[31:0];
        CfgAmplitude:      amplitude_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  so_phase u_phase (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tick_i            (tick_i),
    .phase_increment_i (phase_increment_q),
    .phase_offset_i    (phase_offset_q),
    .valid_o           (ph_valid),
    .ready_i           (ph_ready),
    .sel_o             (ph_sel)
  );

  so_lut u_lut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .ready_o (ph_ready),
    .sel_i   (ph_sel),
    .valid_o (lut_valid),
    .ready_i (lut_ready),
    .lut_o   (lut)
  );

  so_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (lut_valid),
    .ready_o     (lut_ready),
    .lut_i       (lut),
    .amplitude_i (amplitude_q),
    .sample_o    (sample_o)
  );

endmodule
